>>> src/act_pkg.sv
// act_pkg: shared types and constants for the alarm countdown timer
// operation codes, packed hh:mm:ss type and status structs between modules
// no dependencies
package act_pkg;

    localparam int unsigned HOUR_W = 5;
    localparam int unsigned UNIT_W = 6;
    localparam int unsigned OP_W   = 4;

    localparam logic [HOUR_W-1:0] LAST_HOUR = HOUR_W'(23);
    localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(59);

    typedef enum logic [OP_W-1:0] {
        OP_HOUR_UP      = 4'd0,
        OP_HOUR_DOWN    = 4'd1,
        OP_MINUTE_UP    = 4'd2,
        OP_MINUTE_DOWN  = 4'd3,
        OP_SECOND_UP    = 4'd4,
        OP_SECOND_DOWN  = 4'd5,
        OP_ALARM_TOGGLE = 4'd6,
        OP_LOAD         = 4'd7,
        OP_RELOAD       = 4'd8,
        OP_TICK         = 4'd9,
        OP_ARM          = 4'd10,
        OP_CHECK        = 4'd11,
        OP_SET_PAUSE    = 4'd12
    } op_t;

    // hour in the top bits, so a packed compare orders times correctly
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [UNIT_W-1:0] minute;
        logic [UNIT_W-1:0] second;
    } hms_t;

    typedef struct packed {
        hms_t edit;
        logic alarm_enabled;
        logic fired;
    } edit_stat_t;

    typedef struct packed {
        hms_t remain;
        logic paused;
        logic expired;
        logic is_zero;
    } count_stat_t;

endpackage

>>> src/act_in_if.sv
// act_in_if: input channel of the alarm countdown timer
// valid/ready handshake with one operation and the current time
// depends on act_pkg
interface act_in_if
    import act_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [HOUR_W-1:0] now_hour;
    logic [UNIT_W-1:0] now_minute;
    logic [UNIT_W-1:0] now_second;
    logic              pause_value;

    modport source (
        output valid, operation, now_hour, now_minute, now_second, pause_value,
        input  ready
    );
    modport sink (
        input  valid, operation, now_hour, now_minute, now_second, pause_value,
        output ready
    );
endinterface

>>> src/act_out_if.sv
// act_out_if: result channel of the alarm countdown timer
// valid/ready handshake with the state after each operation and its flags
// depends on act_pkg
interface act_out_if
    import act_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] edit_hour_out;
    logic [UNIT_W-1:0] edit_minute_out;
    logic [UNIT_W-1:0] edit_second_out;
    logic [HOUR_W-1:0] remain_hour_out;
    logic [UNIT_W-1:0] remain_minute_out;
    logic [UNIT_W-1:0] remain_second_out;
    logic              alarm_enabled_out;
    logic              paused_out;
    logic              countdown_expired;
    logic              countdown_is_zero;
    logic              alarm_fired;

    modport source (
        output valid, edit_hour_out, edit_minute_out, edit_second_out,
               remain_hour_out, remain_minute_out, remain_second_out,
               alarm_enabled_out, paused_out, countdown_expired,
               countdown_is_zero, alarm_fired,
        input  ready
    );
    modport sink (
        input  valid, edit_hour_out, edit_minute_out, edit_second_out,
               remain_hour_out, remain_minute_out, remain_second_out,
               alarm_enabled_out, paused_out, countdown_expired,
               countdown_is_zero, alarm_fired,
        output ready
    );
endinterface

>>> src/act_edit.sv
// act_edit: edited hh:mm:ss setting, alarm enable, target and fired latch
// updates on each transfer and gives the post-operation status
// depends on act_pkg
module act_edit
    import act_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  op_t        op,
    input  hms_t       now,
    output hms_t       edit,
    output edit_stat_t stat_next
);

    hms_t edit_reg, edit_next;
    hms_t target_reg, target_next;
    logic enable_reg, enable_next;
    logic latched_reg, latched_next;
    logic fired;

    assign edit = edit_reg;

    always_comb
    begin
        edit_next    = edit_reg;
        target_next  = target_reg;
        enable_next  = enable_reg;
        latched_next = latched_reg;
        fired        = 1'b0;
        unique case (op)
            OP_HOUR_UP:
                edit_next.hour = (edit_reg.hour == LAST_HOUR) ? '0 : edit_reg.hour + 1'b1;
            OP_HOUR_DOWN:
                edit_next.hour = (edit_reg.hour == '0) ? LAST_HOUR : edit_reg.hour - 1'b1;
            OP_MINUTE_UP:
                edit_next.minute = (edit_reg.minute == LAST_UNIT) ? '0
                                   : edit_reg.minute + 1'b1;
            OP_MINUTE_DOWN:
                edit_next.minute = (edit_reg.minute == '0) ? LAST_UNIT
                                   : edit_reg.minute - 1'b1;
            OP_SECOND_UP:
                edit_next.second = (edit_reg.second == LAST_UNIT) ? '0
                                   : edit_reg.second + 1'b1;
            OP_SECOND_DOWN:
                edit_next.second = (edit_reg.second == '0) ? LAST_UNIT
                                   : edit_reg.second - 1'b1;
            OP_ALARM_TOGGLE:
                enable_next = ~enable_reg;
            OP_ARM:
            begin
                target_next  = edit_reg;
                latched_next = 1'b0;
            end
            OP_CHECK:
            begin
                // packed compare is hour, then minute, then second
                if (enable_reg && !latched_reg && (now >= target_reg))
                begin
                    fired        = 1'b1;
                    latched_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat_next = '{edit: edit_next, alarm_enabled: enable_next, fired: fired};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_reg    <= '0;
            target_reg  <= '0;
            enable_reg  <= 1'b0;
            latched_reg <= 1'b0;
        end
        else if (accept)
        begin
            edit_reg    <= edit_next;
            target_reg  <= target_next;
            enable_reg  <= enable_next;
            latched_reg <= latched_next;
        end
    end

endmodule

>>> src/act_count.sv
// act_count: countdown start value, remaining time and pause flag
// one-second borrow decrement on tick, reports expiry at zero
// depends on act_pkg
module act_count
    import act_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  op_t         op,
    input  logic        pause_value,
    input  hms_t        edit,
    output count_stat_t stat_next
);

    hms_t start_reg, start_next;
    hms_t remain_reg, remain_next;
    logic paused_reg, paused_next;
    logic expired;

    always_comb
    begin
        start_next  = start_reg;
        remain_next = remain_reg;
        paused_next = paused_reg;
        expired     = 1'b0;
        unique case (op)
            OP_LOAD:
            begin
                start_next  = edit;
                remain_next = edit;
                paused_next = 1'b0;
            end
            OP_RELOAD:
            begin
                remain_next = start_reg;
                paused_next = 1'b0;
            end
            OP_TICK:
            begin
                if (!paused_reg)
                begin
                    priority if (remain_reg.second != '0)
                    begin
                        remain_next.second = remain_reg.second - 1'b1;
                    end
                    else if (remain_reg.minute != '0)
                    begin
                        remain_next.minute = remain_reg.minute - 1'b1;
                        remain_next.second = LAST_UNIT;
                    end
                    else if (remain_reg.hour != '0)
                    begin
                        remain_next.hour   = remain_reg.hour - 1'b1;
                        remain_next.minute = LAST_UNIT;
                        remain_next.second = LAST_UNIT;
                    end
                    else
                    begin
                        expired = 1'b1;
                    end
                end
            end
            OP_SET_PAUSE:
                paused_next = pause_value;
            default:
            begin
            end
        endcase
    end

    assign stat_next = '{remain: remain_next, paused: paused_next, expired: expired,
                         is_zero: (remain_next == '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            remain_reg <= '0;
            paused_reg <= 1'b0;
        end
        else if (accept)
        begin
            start_reg  <= start_next;
            remain_reg <= remain_next;
            paused_reg <= paused_next;
        end
    end

endmodule

>>> src/alarm_countdown_timer_top.sv
// alarm_countdown_timer_top: hh:mm:ss editor with countdown and alarm compare
// instantiates act_edit and act_count, holds the result register
// depends on act_pkg, act_in_if, act_out_if
//
//  channel  | dir | contents
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | operation, now_hour/minute/second, pause_value
//  out_ch   | out | edit and remain hh:mm:ss, enable/pause flags, expiry,
//           |     | zero and fired flags
//
// every transfer on in_ch yields exactly one result, offered the cycle after
// one item per cycle while out_ch is not stalled: state update and result capture share a single edge
// in_ch.ready is high while the result register is empty or being drained
// reset clears all state to zero and empties the result register
// a stalled out_ch holds its result and blocks in_ch until taken
module alarm_countdown_timer_top
    import act_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    act_in_if.sink    in_ch,
    act_out_if.source out_ch
);

    logic        accept;
    op_t         op;
    hms_t        now;
    hms_t        edit;
    edit_stat_t  edit_stat;
    count_stat_t count_stat;

    // result register
    logic        out_valid_reg;
    edit_stat_t  edit_res_reg;
    count_stat_t count_res_reg;

    // take a new item whenever the result slot is free or freeing this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // codes above set pause fall to the default arm and change nothing
    assign op  = op_t'(in_ch.operation);
    assign now = '{hour: in_ch.now_hour, minute: in_ch.now_minute,
                   second: in_ch.now_second};

    act_edit u_edit (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .now       (now),
        .edit      (edit),
        .stat_next (edit_stat)
    );

    act_count u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .pause_value (in_ch.pause_value),
        .edit        (edit),
        .stat_next   (count_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            edit_res_reg  <= edit_stat;
            count_res_reg <= count_stat;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.edit_hour_out     = edit_res_reg.edit.hour;
    assign out_ch.edit_minute_out   = edit_res_reg.edit.minute;
    assign out_ch.edit_second_out   = edit_res_reg.edit.second;
    assign out_ch.remain_hour_out   = count_res_reg.remain.hour;
    assign out_ch.remain_minute_out = count_res_reg.remain.minute;
    assign out_ch.remain_second_out = count_res_reg.remain.second;
    assign out_ch.alarm_enabled_out = edit_res_reg.alarm_enabled;
    assign out_ch.paused_out        = count_res_reg.paused;
    assign out_ch.countdown_expired = count_res_reg.expired;
    assign out_ch.countdown_is_zero = count_res_reg.is_zero;
    assign out_ch.alarm_fired       = edit_res_reg.fired;

endmodule

>>> src/act_checker.sv
// act_checker: port-level checks on the alarm countdown timer
// bound to alarm_countdown_timer_top through its channel signals
// depends on act_pkg
module act_checker
    import act_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [HOUR_W-1:0] remain_hour,
    input logic [UNIT_W-1:0] remain_minute,
    input logic [UNIT_W-1:0] remain_second,
    input logic              alarm_enabled,
    input logic              expired,
    input logic              is_zero,
    input logic              fired
);

    // every input transfer shows a result the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after input transfer");

    // a stalled result stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // expiry only reported with nothing left
    a_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expired |-> is_zero)
        else $error("expiry with time remaining");

    a_fired_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> alarm_enabled)
        else $error("alarm fired while disabled");

    a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (remain_hour <= LAST_HOUR) && (remain_minute <= LAST_UNIT)
                      && (remain_second <= LAST_UNIT))
        else $error("remaining time out of range");

endmodule

bind alarm_countdown_timer_top act_checker u_act_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .remain_hour   (out_ch.remain_hour_out),
    .remain_minute (out_ch.remain_minute_out),
    .remain_second (out_ch.remain_second_out),
    .alarm_enabled (out_ch.alarm_enabled_out),
    .expired       (out_ch.countdown_expired),
    .is_zero       (out_ch.countdown_is_zero),
    .fired         (out_ch.alarm_fired)
);
